// ----- hw/rtl/ldt_pkg.sv -----
// Package for the line distance transform: widths, memory entry layout,
// datapath operation codes and the controller/datapath status bundle.
// No dependencies.
package ldt_pkg;

    // Line and cost sizing.
    localparam int LINE_LENGTH = 64;
    localparam int COST_BITS   = 24;
    localparam int IDX_BITS    = $clog2(LINE_LENGTH);

    // Derived widths: the squared index, the cost plus the squared index,
    // the signed boundary numerator and denominator, and their cross products.
    localparam int SQ_BITS   = 2 * IDX_BITS;
    localparam int FQ_BITS   = COST_BITS + 1;
    localparam int NUM_BITS  = COST_BITS + 3;
    localparam int DEN_BITS  = IDX_BITS + 2;
    localparam int PROD_BITS = NUM_BITS + DEN_BITS;

    localparam logic [COST_BITS-1:0] INF_CODE = {COST_BITS{1'b1}};

    // One envelope entry: parabola position and the boundary at its left.
    typedef struct packed {
        logic [IDX_BITS-1:0]        pos;
        logic signed [NUM_BITS-1:0] num;
        logic signed [DEN_BITS-1:0] den;
    } ldt_env_t;

    // Operations the controller asks of the datapath, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_COST_Q,
        OP_FQ,
        OP_FIRST,
        OP_RD_ENV_K,
        OP_RD_ENV_K1,
        OP_RD_COST_V,
        OP_NUMDEN,
        OP_MUL,
        OP_POP,
        OP_PUSH,
        OP_NEXT_Q,
        OP_EMIT_INIT,
        OP_SET_INF,
        OP_ADV_K,
        OP_SUM,
        OP_OUT
    } ldt_op_t;

    // Status flags the datapath returns to the controller.
    typedef struct packed {
        logic line_end;   // the incoming sample closes the line
        logic cost_inf;   // the cost just read is the infinite code
        logic any;        // the envelope holds at least one parabola
        logic pop;        // the top parabola is hidden by the new one
        logic k_lt_top;   // envelope index is below the top
        logic bnd_below;  // the next boundary lies strictly left of q
        logic q_last;     // q is the last position of the line
        logic out_free;   // the output register can take a transaction
    } ldt_status_t;

endpackage

// ----- hw/rtl/line_distance_transform_top.sv -----
// Line distance transform: one sample is taken per input transaction, and only while idle. On the last
// sample the envelope is built: infinite samples are skipped, the first finite sample starts it, and each
// later finite sample pops the parabolas it hides (each is popped once at most), then is pushed.
// Each result then advances past the boundaries left of its position and evaluates the parabola there,
// or gives the infinite code on an all-infinite line. The single memory read ports serialise these steps.
// Reset (aresetn, synchronous, active low) empties the line and the output; memories keep data.
module line_distance_transform_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ldt_pkg::COST_BITS-1:0] s_sample_cost,
    input  logic                          s_last_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ldt_pkg::COST_BITS-1:0] m_squared_distance,
    output logic                          m_last_result
);
    import ldt_pkg::*;

    ldt_op_t     op;
    ldt_status_t status;

    // Sequencer.
    ldt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    // Storage and arithmetic.
    ldt_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .op                 (op),
        .status             (status),
        .s_sample_cost      (s_sample_cost),
        .s_last_sample      (s_last_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_squared_distance (m_squared_distance),
        .m_last_result      (m_last_result)
    );

endmodule

// ----- hw/rtl/ldt_datapath.sv -----
// Datapath of the line distance transform: sample and envelope memories,
// index registers, cross-multiplication compare and the output register.
// Depends on ldt_pkg; driven by ldt_ctrl through an operation code.
module ldt_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ldt_pkg::ldt_op_t              op,
    output ldt_pkg::ldt_status_t          status,
    input  logic [ldt_pkg::COST_BITS-1:0] s_sample_cost,
    input  logic                          s_last_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ldt_pkg::COST_BITS-1:0] m_squared_distance,
    output logic                          m_last_result
);
    import ldt_pkg::*;

    // Memories with registered reads.
    logic [COST_BITS-1:0] cost_mem [LINE_LENGTH];
    ldt_env_t             env_mem  [LINE_LENGTH];
    logic [COST_BITS-1:0] cost_rd_reg;
    ldt_env_t             env_rd_reg;

    // Control and payload registers.
    logic [IDX_BITS-1:0]         cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]         last_idx_reg, last_idx_next;
    logic [IDX_BITS-1:0]         q_reg, q_next;
    logic [IDX_BITS-1:0]         k_reg, k_next;
    logic [IDX_BITS-1:0]         top_reg, top_next;
    logic                        any_reg, any_next;
    logic [FQ_BITS-1:0]          fq_reg, fq_next;
    logic signed [NUM_BITS-1:0]  num_reg, num_next;
    logic signed [DEN_BITS-1:0]  den_reg, den_next;
    logic signed [PROD_BITS-1:0] p1_reg, p1_next;
    logic signed [PROD_BITS-1:0] p2_reg, p2_next;
    logic [COST_BITS-1:0]        res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    logic [COST_BITS-1:0]        m_dist_reg, m_dist_next;
    logic                        m_last_reg, m_last_next;

    // Combinational helpers.
    logic [IDX_BITS-1:0]        v_idx;
    logic [SQ_BITS-1:0]         q_sq;
    logic [SQ_BITS-1:0]         v_sq;
    logic [IDX_BITS-1:0]        dist_abs;
    logic [SQ_BITS-1:0]         dist_sq;
    logic [FQ_BITS-1:0]         sum_full;
    logic signed [NUM_BITS-1:0] q_signed;
    logic signed [NUM_BITS-1:0] q_times_den;
    logic [IDX_BITS-1:0]        cost_raddr;
    logic [IDX_BITS-1:0]        env_raddr;
    logic [IDX_BITS-1:0]        env_waddr;
    logic                       env_we;
    ldt_env_t                   env_wdata;
    logic                       line_end;
    logic                       out_free;

    assign v_idx    = env_rd_reg.pos;
    assign q_sq     = SQ_BITS'(q_reg) * SQ_BITS'(q_reg);
    assign v_sq     = SQ_BITS'(v_idx) * SQ_BITS'(v_idx);
    assign dist_abs = (q_reg >= v_idx) ? (q_reg - v_idx) : (v_idx - q_reg);
    assign dist_sq  = SQ_BITS'(dist_abs) * SQ_BITS'(dist_abs);
    assign sum_full = FQ_BITS'(cost_rd_reg) + FQ_BITS'(dist_sq);
    assign q_signed = $signed(NUM_BITS'(q_reg));
    assign q_times_den = q_signed * NUM_BITS'(env_rd_reg.den);

    assign line_end = s_last_sample || (cnt_reg == IDX_BITS'(LINE_LENGTH - 1));
    assign out_free = !m_valid_reg || m_ready;

    // Status back to the controller.
    always_comb begin
        status.line_end  = line_end;
        status.cost_inf  = (cost_rd_reg == INF_CODE);
        status.any       = any_reg;
        status.pop       = (k_reg != '0) && (p1_reg <= p2_reg);
        status.k_lt_top  = (k_reg < top_reg);
        status.bnd_below = (env_rd_reg.num < q_times_den);
        status.q_last    = (q_reg == last_idx_reg);
        status.out_free  = out_free;
    end

    // Memory address and write selection.
    always_comb begin
        cost_raddr = (op == OP_RD_COST_V) ? v_idx : q_reg;
        env_raddr  = (op == OP_RD_ENV_K1) ? (k_reg + 1'b1) : k_reg;
        env_we     = (op == OP_FIRST) || (op == OP_PUSH);
        env_waddr  = (op == OP_FIRST) ? '0 : (k_reg + 1'b1);
        env_wdata.pos = q_reg;
        env_wdata.num = num_reg;
        env_wdata.den = den_reg;
    end

    // Sample store: written on each input transaction.
    always_ff @(posedge aclk) begin
        if (op == OP_LOAD) begin
            cost_mem[cnt_reg] <= s_sample_cost;
        end
        if ((op == OP_RD_COST_Q) || (op == OP_RD_COST_V)) begin
            cost_rd_reg <= cost_mem[cost_raddr];
        end
    end

    // Envelope store: parabola positions with their left boundaries.
    // Entry 0 always has a boundary at minus infinity and entries up to the
    // top hold finite boundaries, so no infinity code is kept.
    always_ff @(posedge aclk) begin
        if (env_we) begin
            env_mem[env_waddr] <= env_wdata;
        end
        if ((op == OP_RD_ENV_K) || (op == OP_RD_ENV_K1)) begin
            env_rd_reg <= env_mem[env_raddr];
        end
    end

    // Register updates per operation.
    always_comb begin
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        q_next        = q_reg;
        k_next        = k_reg;
        top_next      = top_reg;
        any_next      = any_reg;
        fq_next       = fq_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        res_next      = res_reg;
        case (op)
            OP_LOAD: begin
                if (line_end) begin
                    cnt_next      = '0;
                    last_idx_next = cnt_reg;
                    q_next        = '0;
                    any_next      = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_FQ: begin
                fq_next = FQ_BITS'(cost_rd_reg) + FQ_BITS'(q_sq);
                k_next  = top_reg;
            end
            OP_FIRST: begin
                top_next = '0;
                any_next = 1'b1;
            end
            OP_NUMDEN: begin
                num_next = NUM_BITS'(fq_reg) - NUM_BITS'(cost_rd_reg) - NUM_BITS'(v_sq);
                den_next = {1'b0, q_reg - v_idx, 1'b0};
            end
            OP_MUL: begin
                p1_next = PROD_BITS'(num_reg) * PROD_BITS'(env_rd_reg.den);
                p2_next = PROD_BITS'(env_rd_reg.num) * PROD_BITS'(den_reg);
            end
            OP_POP: begin
                k_next = k_reg - 1'b1;
            end
            OP_PUSH: begin
                top_next = k_reg + 1'b1;
            end
            OP_NEXT_Q: begin
                q_next = q_reg + 1'b1;
            end
            OP_EMIT_INIT: begin
                q_next = '0;
                k_next = '0;
            end
            OP_SET_INF: begin
                res_next = INF_CODE;
            end
            OP_ADV_K: begin
                k_next = k_reg + 1'b1;
            end
            OP_SUM: begin
                // Saturate to the infinite code.
                res_next = (sum_full >= FQ_BITS'(INF_CODE)) ? INF_CODE
                                                            : sum_full[COST_BITS-1:0];
            end
            OP_OUT: begin
                q_next = q_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded by the controller, emptied by the consumer.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_dist_next  = m_dist_reg;
        m_last_next  = m_last_reg;
        if (op == OP_OUT) begin
            m_valid_next = 1'b1;
            m_dist_next  = res_reg;
            m_last_next  = (q_reg == last_idx_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_idx_reg <= last_idx_next;
        q_reg        <= q_next;
        k_reg        <= k_next;
        top_reg      <= top_next;
        any_reg      <= any_next;
        fq_reg       <= fq_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        res_reg      <= res_next;
        m_dist_reg   <= m_dist_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_squared_distance = m_dist_reg;
    assign m_last_result      = m_last_reg;

endmodule

// ----- hw/rtl/ldt_ctrl.sv -----
// Controller of the line distance transform: one-hot state machine that
// sequences loading, envelope build and emission.
// Depends on ldt_pkg; issues operation codes to ldt_datapath.
module ldt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ldt_pkg::ldt_status_t status,
    output ldt_pkg::ldt_op_t     op
);
    import ldt_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_BRDQ   = 15'b000000000000010,
        ST_BFQ    = 15'b000000000000100,
        ST_BFIRST = 15'b000000000001000,
        ST_BRDK   = 15'b000000000010000,
        ST_BRDV   = 15'b000000000100000,
        ST_BNUM   = 15'b000000001000000,
        ST_BMUL   = 15'b000000010000000,
        ST_BDEC   = 15'b000000100000000,
        ST_BNEXT  = 15'b000001000000000,
        ST_EHEAD  = 15'b000010000000000,
        ST_ETST   = 15'b000100000000000,
        ST_EV     = 15'b001000000000000,
        ST_ESUM   = 15'b010000000000000,
        ST_EOUT   = 15'b100000000000000
    } ldt_state_t;

    ldt_state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath operation.
    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op = OP_LOAD;
                    if (status.line_end) begin
                        state_next = ST_BRDQ;
                    end
                end
            end
            // Envelope build: read the sample at q.
            ST_BRDQ: begin
                op         = OP_RD_COST_Q;
                state_next = ST_BFQ;
            end
            ST_BFQ: begin
                op = OP_FQ;
                if (status.cost_inf) begin
                    state_next = ST_BNEXT;
                end else if (!status.any) begin
                    state_next = ST_BFIRST;
                end else begin
                    state_next = ST_BRDK;
                end
            end
            ST_BFIRST: begin
                op         = OP_FIRST;
                state_next = ST_BNEXT;
            end
            // Compare the new parabola against the envelope entry k.
            ST_BRDK: begin
                op         = OP_RD_ENV_K;
                state_next = ST_BRDV;
            end
            ST_BRDV: begin
                op         = OP_RD_COST_V;
                state_next = ST_BNUM;
            end
            ST_BNUM: begin
                op         = OP_NUMDEN;
                state_next = ST_BMUL;
            end
            ST_BMUL: begin
                op         = OP_MUL;
                state_next = ST_BDEC;
            end
            ST_BDEC: begin
                if (status.pop) begin
                    op         = OP_POP;
                    state_next = ST_BRDK;
                end else begin
                    op         = OP_PUSH;
                    state_next = ST_BNEXT;
                end
            end
            ST_BNEXT: begin
                if (status.q_last) begin
                    op         = OP_EMIT_INIT;
                    state_next = ST_EHEAD;
                end else begin
                    op         = OP_NEXT_Q;
                    state_next = ST_BRDQ;
                end
            end
            // Emission: advance k past boundaries left of q, then evaluate; an empty envelope gives the infinite code.
            ST_EHEAD: begin
                if (!status.any) begin
                    op         = OP_SET_INF;
                    state_next = ST_EOUT;
                end else if (status.k_lt_top) begin
                    op         = OP_RD_ENV_K1;
                    state_next = ST_ETST;
                end else begin
                    op         = OP_RD_ENV_K;
                    state_next = ST_EV;
                end
            end
            ST_ETST: begin
                if (status.bnd_below) begin
                    op         = OP_ADV_K;
                    state_next = ST_EHEAD;
                end else begin
                    op         = OP_RD_ENV_K;
                    state_next = ST_EV;
                end
            end
            ST_EV: begin
                op         = OP_RD_COST_V;
                state_next = ST_ESUM;
            end
            ST_ESUM: begin
                op         = OP_SUM;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                if (status.out_free) begin
                    op = OP_OUT;
                    if (status.q_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EHEAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
